FILE: rtl/core/lru_key_value_cache_macros.svh
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define LKV_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the trigger.
`define LKV_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lkv_pkg.sv
package lkv_pkg;

    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int CAP_BITS    = 5;
    localparam int OCC_BITS    = 5;
    localparam int ENTRIES_DEF = 16;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam int  ADDR_BITS    = 3;
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic {
        MODE_LOOKUP = 1'b0,
        MODE_STORE  = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t                 mode;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic [OCC_BITS-1:0]   occupancy;
    } rsp_t;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    typedef struct packed {
        logic                  below;
        logic [VALUE_BITS-1:0] rd;
    } chain_t;

endpackage

FILE: rtl/core/lru_key_value_cache.sv
// The response is registered and valid in the cycle after the request transfer.
// Throughput: one request per cycle; all cells compare and shift in the same cycle.
// A new request is held off only while a response waits under stall.
// Reset: asynchronous, active low; empties every cell, occupancy 0, capacity 16.
// No clearing pass: the cache is ready in the first cycle after reset.
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  lkv_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output lkv_pkg::rsp_t                  rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lkv_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import lkv_pkg::*;

    `include "lru_key_value_cache_macros.svh"

    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;
    localparam logic [CMPW-1:0] ENTRIES_W = CMPW'(ENTRIES);

    logic [CAP_BITS-1:0]   cap_reg, cap_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  go;
    logic                  hit;
    logic [VALUE_BITS-1:0] hit_value;
    logic [ENTRIES-1:0]    valid_vec;
    logic [ENTRIES-1:0]    match_vec;
    logic [CMPW-1:0]       cap_w, eff_cap, count_w, occ_w;
    logic                  full;
    logic [CW-1:0]         last;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign prdata    = 32'(cap_reg);
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign go        = req_valid && !req_stall;

    always_comb
    begin
        cap_w   = CMPW'(cap_reg);
        count_w = CMPW'(count_reg);
        if (cap_w == '0)
        begin
            eff_cap = CMPW'(1);
        end
        else if (cap_w > ENTRIES_W)
        begin
            eff_cap = ENTRIES_W;
        end
        else
        begin
            eff_cap = cap_w;
        end
        full = (count_w >= eff_cap);
        last = full ? (count_reg - CW'(1)) : count_reg;
    end

    lkv_chain #(
        .ENTRIES (ENTRIES),
        .CW      (CW)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .cmd       (req),
        .last      (last),
        .hit       (hit),
        .hit_value (hit_value),
        .valid_vec (valid_vec),
        .match_vec (match_vec)
    );

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_write && (count_reg == '0))
        begin
            cap_next = pwdata[CAP_BITS-1:0];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (go && (req.mode == MODE_STORE) && !hit && !full)
        begin
            count_next = count_reg + CW'(1);
        end
        occ_w = CMPW'(count_next);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (go)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.hit        = hit;
            rsp_next.read_value = (hit && (req.mode == MODE_LOOKUP)) ? hit_value : '0;
            rsp_next.occupancy  = occ_w[OCC_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `LKV_ASSERT_ALWAYS(a_count_matches_valid, $countones(valid_vec) == count_reg, "occupancy does not match valid cells")
    `LKV_ASSERT_ALWAYS(a_single_match, $onehot0(match_vec), "key held in more than one cell")
    `LKV_ASSERT_ALWAYS(a_count_bound, CMPW'(count_reg) <= eff_cap, "occupancy above capacity")
    `LKV_ASSERT_NEXT(a_rsp_follows, go, rsp_valid_reg, "transfer without response")

endmodule

FILE: rtl/core/lkv_cell.sv
module lkv_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lkv_pkg::entry_t               prev_entry,
    input  logic                          shift,
    input  logic [lkv_pkg::KEY_BITS-1:0]  probe_key,
    input  lkv_pkg::chain_t               chain_in,
    output lkv_pkg::entry_t               entry,
    output logic                          match,
    output lkv_pkg::chain_t               chain_out
);
    import lkv_pkg::*;

    logic                  valid_reg, valid_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (shift)
        begin
            valid_next = prev_entry.valid;
            key_next   = prev_entry.key;
            value_next = prev_entry.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign match           = valid_reg && (key_reg == probe_key);
    assign chain_out.below = chain_in.below | match;
    assign chain_out.rd    = chain_in.rd | (match ? value_reg : '0);

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

endmodule

FILE: rtl/core/lkv_chain.sv
module lkv_chain #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
    parameter int CW      = $clog2(ENTRIES + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            go,
    input  lkv_pkg::req_t                   cmd,
    input  logic [CW-1:0]                   last,
    output logic                            hit,
    output logic [lkv_pkg::VALUE_BITS-1:0]  hit_value,
    output logic [ENTRIES-1:0]              valid_vec,
    output logic [ENTRIES-1:0]              match_vec
);
    import lkv_pkg::*;

    entry_t             cell_entry [ENTRIES];
    entry_t             feed       [ENTRIES];
    chain_t             chain_link [ENTRIES+1];
    logic [ENTRIES-1:0] shift;
    entry_t             head;
    logic               store;

    assign chain_link[ENTRIES] = '0;
    assign hit       = chain_link[0].below;
    assign hit_value = chain_link[0].rd;
    assign store     = (cmd.mode == MODE_STORE);

    // Head of the chain takes the touched or new entry as most recent.
    always_comb
    begin
        head.valid = 1'b1;
        head.key   = cmd.key;
        head.value = store ? cmd.value : hit_value;
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);

        if (i == 0)
        begin : g_head
            assign feed[i] = head;
        end
        else
        begin : g_body
            assign feed[i] = cell_entry[i-1];
        end

        assign shift[i]     = go && (hit ? chain_link[i].below : (store && (IDX <= last)));
        assign valid_vec[i] = cell_entry[i].valid;

        lkv_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .prev_entry (feed[i]),
            .shift      (shift[i]),
            .probe_key  (cmd.key),
            .chain_in   (chain_link[i+1]),
            .entry      (cell_entry[i]),
            .match      (match_vec[i]),
            .chain_out  (chain_link[i])
        );
    end

endmodule
